[hdl/wtpd_pkg.sv]
// Shared types, constants and register codes for the wall-tracking PD steering block.
package wtpd_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [13:0] VOLT_MAX = 14'd12000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MM     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DEGREES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_SIDE     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_VOLTAGE  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID_MM  = 4'd7;

  // Reset values of the registers that do not reset to zero.
  localparam logic [7:0]  PROP_GAIN_RST    = 8'd30;
  localparam logic [7:0]  DERIV_GAIN_RST   = 8'd5;
  localparam logic [15:0] MAX_VALID_MM_RST = 16'd2000;

  // Operation codes of an input beat.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Wall side codes.
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_DISTANCE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  typedef struct packed {
    logic [15:0] target_mm;
    logic [30:0] drive_degrees;
    logic        wall_side;
    logic [13:0] base_voltage;
    logic [31:0] timeout_ms;
    logic [7:0]  prop_gain;
    logic [7:0]  deriv_gain;
    logic [15:0] max_valid_mm;
  } cfg_t;

  typedef struct packed {
    logic timed_out;
    logic dist_reached;
  } stop_t;

endpackage

[hdl/wtpd_if.sv]
// Valid/ready channel interfaces for the input, result and configuration beats.
interface wtpd_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [31:0] now_ms;
  logic        [15:0] sensor_mm;
  logic signed [31:0] left_position;
  logic signed [31:0] right_position;

  modport source (output valid, op, now_ms, sensor_mm, left_position, right_position,
                  input ready);
  modport sink (input valid, op, now_ms, sensor_mm, left_position, right_position,
                output ready);
endinterface

interface wtpd_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] left_voltage;
  logic [13:0] right_voltage;
  logic [1:0]  status;

  modport source (output valid, left_voltage, right_voltage, status, input ready);
  modport sink (input valid, left_voltage, right_voltage, status, output ready);
endinterface

interface wtpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/wtpd_cfg_regs.sv]
// Configuration register file written through the configuration channel.
module wtpd_cfg_regs
  import wtpd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  wtpd_cfg_if.sink       cfg_if,
  output cfg_t           cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_TARGET_MM:     cfg_nxt.target_mm     = cfg_if.data[15:0];
        REG_DRIVE_DEGREES: cfg_nxt.drive_degrees = cfg_if.data[30:0];
        REG_WALL_SIDE:     cfg_nxt.wall_side     = cfg_if.data[0];
        REG_BASE_VOLTAGE:  cfg_nxt.base_voltage  = cfg_if.data[13:0];
        REG_TIMEOUT_MS:    cfg_nxt.timeout_ms    = cfg_if.data[31:0];
        REG_PROP_GAIN:     cfg_nxt.prop_gain     = cfg_if.data[7:0];
        REG_DERIV_GAIN:    cfg_nxt.deriv_gain    = cfg_if.data[7:0];
        REG_MAX_VALID_MM:  cfg_nxt.max_valid_mm  = cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mm     <= '0;
      cfg_r.drive_degrees <= '0;
      cfg_r.wall_side     <= SIDE_LEFT;
      cfg_r.base_voltage  <= '0;
      cfg_r.timeout_ms    <= '0;
      cfg_r.prop_gain     <= PROP_GAIN_RST;
      cfg_r.deriv_gain    <= DERIV_GAIN_RST;
      cfg_r.max_valid_mm  <= MAX_VALID_MM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/wtpd_stop_check.sv]
// Timeout and travelled-distance checks for one control sample.
module wtpd_stop_check
  import wtpd_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [31:0] now_ms,
  input  logic [31:0] start_time,
  input  logic [31:0] left_position,
  input  logic [31:0] right_position,
  input  logic [31:0] left_baseline,
  input  logic [31:0] right_baseline,
  output stop_t       stop
);

  logic [31:0] elapsed;
  logic [31:0] left_delta;
  logic [31:0] right_delta;
  logic [31:0] left_mag;
  logic [31:0] right_mag;
  logic [32:0] travel;
  logic [31:0] travel_limit;

  // Elapsed time wraps with the millisecond counter.
  assign elapsed = now_ms - start_time;

  // A wrapped delta read as signed; the magnitude of the most negative value is 2^31.
  assign left_delta  = left_position - left_baseline;
  assign right_delta = right_position - right_baseline;
  assign left_mag    = left_delta[31] ? (~left_delta + 32'd1) : left_delta;
  assign right_mag   = right_delta[31] ? (~right_delta + 32'd1) : right_delta;

  assign travel       = {1'b0, left_mag} + {1'b0, right_mag};
  assign travel_limit = {cfg.drive_degrees, 1'b0};

  assign stop.timed_out    = (elapsed >= cfg.timeout_ms);
  assign stop.dist_reached = (travel >= {1'b0, travel_limit});

endmodule

[hdl/wtpd_pd_core.sv]
// Wall error, PD correction and per-side drive voltages for one control sample.
module wtpd_pd_core
  import wtpd_pkg::*;
(
  input  cfg_t               cfg,
  input  logic        [15:0] sensor_mm,
  input  logic signed [17:0] prev_error,
  output logic signed [17:0] error,
  output logic        [13:0] left_voltage,
  output logic        [13:0] right_voltage
);

  logic signed [18:0] err_delta;
  logic signed [26:0] p_term;
  logic signed [27:0] d_term;
  logic signed [28:0] corr_raw;
  logic signed [28:0] base_wide;
  logic signed [14:0] corr;
  logic signed [16:0] base_s;
  logic signed [16:0] corr_ext;
  logic signed [16:0] left_raw;
  logic signed [16:0] right_raw;
  logic signed [16:0] volt_max_s;

  // Readings at or beyond the valid limit carry no wall information.
  assign error = (sensor_mm < cfg.max_valid_mm)
               ? ($signed({2'b00, cfg.target_mm}) - $signed({2'b00, sensor_mm}))
               : 18'sd0;

  assign err_delta = {error[17], error} - {prev_error[17], prev_error};
  assign p_term    = $signed({19'd0, cfg.prop_gain}) * $signed({{9{error[17]}}, error});
  assign d_term    = $signed({20'd0, cfg.deriv_gain})
                   * $signed({{9{err_delta[18]}}, err_delta});
  assign corr_raw  = {{2{p_term[26]}}, p_term} + {d_term[27], d_term};

  assign base_wide = $signed({15'd0, cfg.base_voltage});

  always_comb begin
    if (corr_raw > base_wide) begin
      corr = $signed({1'b0, cfg.base_voltage});
    end else if (corr_raw < -base_wide) begin
      corr = -$signed({1'b0, cfg.base_voltage});
    end else begin
      corr = corr_raw[14:0];
    end
  end

  assign base_s     = $signed({3'd0, cfg.base_voltage});
  assign corr_ext   = {{2{corr[14]}}, corr};
  assign volt_max_s = $signed({3'd0, VOLT_MAX});

  // The sensor side steers away from or toward the wall by the sign of the error.
  assign left_raw  = (cfg.wall_side == SIDE_RIGHT) ? (base_s + corr_ext) : (base_s - corr_ext);
  assign right_raw = (cfg.wall_side == SIDE_RIGHT) ? (base_s - corr_ext) : (base_s + corr_ext);

  always_comb begin
    if (left_raw < 17'sd0) begin
      left_voltage = '0;
    end else if (left_raw > volt_max_s) begin
      left_voltage = VOLT_MAX;
    end else begin
      left_voltage = left_raw[13:0];
    end
    if (right_raw < 17'sd0) begin
      right_voltage = '0;
    end else if (right_raw > volt_max_s) begin
      right_voltage = VOLT_MAX;
    end else begin
      right_voltage = right_raw[13:0];
    end
  end

endmodule

[hdl/wall_tracking_pd_steering_top.sv]
// Top level of the wall-tracking PD steering block for a differential drive.
//
// Channels: in_if carries start and sample beats (op, time, wall reading and both
// encoder positions), out_if returns exactly one result beat per input beat with the
// left and right drive in millivolts and a status code, and cfg_if writes the eight
// configuration registers by index. Configuration writes are always accepted.
// An accepted input beat waits in the input register, then the PD path computes its
// result into the output register. Throughput is one beat per cycle while the
// receiver keeps out_if.ready high; the input register and the output register
// form a two-stage pipeline, so a new beat is taken while a finished result
// still waits to be taken. When the receiver stalls, the output register holds its
// beat, the input register fills, and in_if.ready drops only once both are occupied.
// Run state (start time, encoder baselines, previous error, running flag) is updated
// as a beat moves from the input register to the output register, so back-to-back
// beats see each other's effect in order.
// Reset (rst_n low, synchronous) empties both stages, puts the block in the idle
// state and loads the register defaults: gains 30 and 5, valid limit 2000 mm.
module wall_tracking_pd_steering_top
  import wtpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wtpd_in_if.sink     in_if,
  wtpd_out_if.source  out_if,
  wtpd_cfg_if.sink    cfg_if
);

  cfg_t cfg;

  // Input register stage.
  logic               s1_vld_r;
  logic               s1_op_r;
  logic        [31:0] s1_now_r;
  logic        [15:0] s1_sensor_r;
  logic        [31:0] s1_lpos_r;
  logic        [31:0] s1_rpos_r;

  // Run state.
  logic signed [17:0] prev_err_r;
  logic signed [17:0] prev_err_nxt;
  logic        [31:0] start_time_r;
  logic        [31:0] start_time_nxt;
  logic        [31:0] lbase_r;
  logic        [31:0] lbase_nxt;
  logic        [31:0] rbase_r;
  logic        [31:0] rbase_nxt;
  logic               running_r;
  logic               running_nxt;

  // Output register stage.
  logic               out_vld_r;
  logic        [13:0] out_lv_r;
  logic        [13:0] out_lv_nxt;
  logic        [13:0] out_rv_r;
  logic        [13:0] out_rv_nxt;
  logic        [1:0]  out_st_r;
  logic        [1:0]  out_st_nxt;

  logic               in_fire;
  logic               out_free;
  logic               s1_fire;

  stop_t              stop;
  logic signed [17:0] pd_error;
  logic        [13:0] pd_left;
  logic        [13:0] pd_right;

  wtpd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  wtpd_stop_check u_stop_check (
    .cfg            (cfg),
    .now_ms         (s1_now_r),
    .start_time     (start_time_r),
    .left_position  (s1_lpos_r),
    .right_position (s1_rpos_r),
    .left_baseline  (lbase_r),
    .right_baseline (rbase_r),
    .stop           (stop)
  );

  wtpd_pd_core u_pd_core (
    .cfg           (cfg),
    .sensor_mm     (s1_sensor_r),
    .prev_error    (prev_err_r),
    .error         (pd_error),
    .left_voltage  (pd_left),
    .right_voltage (pd_right)
  );

  // The output register can take a new beat when it is empty or being drained.
  assign out_free    = !out_vld_r || out_if.ready;
  assign s1_fire     = s1_vld_r && out_free;
  assign in_if.ready = !s1_vld_r || out_free;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid         = out_vld_r;
  assign out_if.left_voltage  = out_lv_r;
  assign out_if.right_voltage = out_rv_r;
  assign out_if.status        = out_st_r;

  // Result and run-state update for the beat in the input register. Checks go in
  // order: start, idle, timeout, distance reached, then the PD steering.
  always_comb begin
    prev_err_nxt   = prev_err_r;
    start_time_nxt = start_time_r;
    lbase_nxt      = lbase_r;
    rbase_nxt      = rbase_r;
    running_nxt    = running_r;
    out_lv_nxt     = '0;
    out_rv_nxt     = '0;
    out_st_nxt     = ST_RUNNING;
    if (s1_op_r == OP_START) begin
      start_time_nxt = s1_now_r;
      lbase_nxt      = s1_lpos_r;
      rbase_nxt      = s1_rpos_r;
      prev_err_nxt   = '0;
      running_nxt    = 1'b1;
    end else if (!running_r) begin
      out_st_nxt = ST_IDLE;
    end else if (stop.timed_out) begin
      running_nxt = 1'b0;
      out_st_nxt  = ST_TIMEOUT;
    end else if (stop.dist_reached) begin
      running_nxt = 1'b0;
      out_st_nxt  = ST_DISTANCE;
    end else begin
      prev_err_nxt = pd_error;
      out_lv_nxt   = pd_left;
      out_rv_nxt   = pd_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      running_r    <= 1'b0;
      prev_err_r   <= '0;
      start_time_r <= '0;
      lbase_r      <= '0;
      rbase_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        running_r    <= running_nxt;
        prev_err_r   <= prev_err_nxt;
        start_time_r <= start_time_nxt;
        lbase_r      <= lbase_nxt;
        rbase_r      <= rbase_nxt;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_if.op;
      s1_now_r    <= in_if.now_ms;
      s1_sensor_r <= in_if.sensor_mm;
      s1_lpos_r   <= in_if.left_position;
      s1_rpos_r   <= in_if.right_position;
    end
    if (s1_fire) begin
      out_lv_r <= out_lv_nxt;
      out_rv_r <= out_rv_nxt;
      out_st_r <= out_st_nxt;
    end
  end

  // A result that is not a running sample never drives the motors.
  a_stop_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_st_r != ST_RUNNING)) |-> (out_lv_r == '0 && out_rv_r == '0))
    else $error("nonzero drive on a stopped or idle result");

  // Every delivered drive stays within the supply limit.
  a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_lv_r <= VOLT_MAX && out_rv_r <= VOLT_MAX))
    else $error("drive voltage above limit");

  // A start beat leaves the block running with a cleared error history.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r == OP_START) |=> (running_r && prev_err_r == '0))
    else $error("start beat did not begin a run");

  // A stop result ends the run.
  a_stop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (out_st_nxt == ST_TIMEOUT || out_st_nxt == ST_DISTANCE)) |=> !running_r)
    else $error("run continued after a stop result");

endmodule

[sim/wall_tracking_pd_steering_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the wall-tracking PD steering block, with its own drive predictor.
module wall_tracking_pd_steering_top_test;
  import wtpd_pkg::*;

  // Watchdog limit on simulation cycles; a correct run finishes before it is reached.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Beats of the random part that reach a running block.
  localparam int RANDOM_ITEMS = 1950;

  // One input beat as the predictor sees it.
  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic [15:0] sensor_mm;
    logic [31:0] left_position;
    logic [31:0] right_position;
  } steer_beat_t;

  // One result beat: both side drives and the run status.
  typedef struct packed {
    logic [13:0] left_voltage;
    logic [13:0] right_voltage;
    logic [1:0]  status;
  } drive_t;

  logic clk;
  logic rst_n;

  wtpd_in_if  steer_in ();
  wtpd_out_if drive_out ();
  wtpd_cfg_if cfg_wr ();

  wall_tracking_pd_steering_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (steer_in),
    .out_if (drive_out),
    .cfg_if (cfg_wr)
  );

  // Predictor copy of the registers and of the run state.
  cfg_t        cfg_shadow;
  logic [31:0] run_start_ms;
  logic [31:0] left_origin;
  logic [31:0] right_origin;
  int          last_error;
  logic        run_active;

  // Drives that the block still owes, oldest first.
  drive_t expected_drive[$];
  // Prediction for the most recently accepted beat; the random runs steer on it.
  drive_t last_prediction;

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int mode_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wall_tracking_pd_steering_top: mismatch");
      $finish;
    end
  end

  // The receiver switches at random times between stall patterns: always ready,
  // mostly ready, a fixed duty cycle, and long stalls where ready is only rarely high.
  // The always-ready stretches let the pipeline run at full rate.
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(32, 256);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      0:       drive_out.ready <= 1'b1;
      1:       drive_out.ready <= ($urandom_range(0, 3) != 0);
      2:       drive_out.ready <= ((cycle_count % 5) < 2);
      default: drive_out.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Every result beat is compared field by field with the oldest owed drive. Inputs are
  // sampled at the edge, so the values seen are the ones that made the handshake.
  always @(posedge clk) begin : check_results
    drive_t want;
    if (rst_n && drive_out.valid && drive_out.ready) begin
      if (expected_drive.size() == 0) begin
        $display("%0t: result beat with nothing owed: left %0d right %0d status %0d",
                 $time, drive_out.left_voltage, drive_out.right_voltage, drive_out.status);
        error_count++;
      end else begin
        want = expected_drive.pop_front();
        if (drive_out.left_voltage !== want.left_voltage) begin
          $display("%0t: left_voltage expected %0d, got %0d",
                   $time, want.left_voltage, drive_out.left_voltage);
          error_count++;
        end
        if (drive_out.right_voltage !== want.right_voltage) begin
          $display("%0t: right_voltage expected %0d, got %0d",
                   $time, want.right_voltage, drive_out.right_voltage);
          error_count++;
        end
        if (drive_out.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, drive_out.status);
          error_count++;
        end
      end
    end
  end

  // Magnitude of one side's travel: the wrapped difference read as signed, so a full
  // half-turn of the 32-bit counter gives 2^31.
  function automatic longint side_travel(input logic [31:0] pos, input logic [31:0] origin);
    logic [31:0] delta;
    delta = pos - origin;
    if (delta[31]) delta = -delta;
    return longint'(delta);
  endfunction

  function automatic longint clamp_volts(input longint v);
    if (v < 0) return 0;
    if (v > longint'(VOLT_MAX)) return longint'(VOLT_MAX);
    return v;
  endfunction

  // Works out the drive for one accepted beat and advances the run state. The checks go
  // in the block's order: start, idle, timeout, distance, and only then the PD step.
  function automatic drive_t predict_drive(input steer_beat_t b);
    drive_t      r;
    logic [31:0] elapsed;
    longint      travel;
    longint      corr;
    longint      base;
    longint      lv;
    longint      rv;
    int          err;
    r = '0;
    r.status = ST_RUNNING;
    if (b.op == OP_START) begin
      run_start_ms = b.now_ms;
      left_origin  = b.left_position;
      right_origin = b.right_position;
      last_error   = 0;
      run_active   = 1'b1;
      return r;
    end
    if (!run_active) begin
      r.status = ST_IDLE;
      return r;
    end
    elapsed = b.now_ms - run_start_ms;
    if (elapsed >= cfg_shadow.timeout_ms) begin
      run_active = 1'b0;
      r.status = ST_TIMEOUT;
      return r;
    end
    travel = side_travel(b.left_position, left_origin)
           + side_travel(b.right_position, right_origin);
    if (travel >= 2 * longint'(cfg_shadow.drive_degrees)) begin
      run_active = 1'b0;
      r.status = ST_DISTANCE;
      return r;
    end
    // A reading at or above the valid limit counts as zero error.
    err = 0;
    if (b.sensor_mm < cfg_shadow.max_valid_mm)
      err = int'({16'd0, cfg_shadow.target_mm}) - int'({16'd0, b.sensor_mm});
    corr = longint'(cfg_shadow.prop_gain) * err
         + longint'(cfg_shadow.deriv_gain) * (longint'(err) - longint'(last_error));
    last_error = err;
    base = longint'(cfg_shadow.base_voltage);
    if (corr > base) corr = base;
    else if (corr < -base) corr = -base;
    // With the wall on the right a positive error turns away from it by speeding up the
    // left side; the left wall mirrors this.
    if (cfg_shadow.wall_side == SIDE_RIGHT) begin
      lv = base + corr;
      rv = base - corr;
    end else begin
      lv = base - corr;
      rv = base + corr;
    end
    lv = clamp_volts(lv);
    rv = clamp_volts(rv);
    r.left_voltage  = lv[13:0];
    r.right_voltage = rv[13:0];
    return r;
  endfunction

  // Sends one beat and records its drive once the block has taken it. Beats go out in
  // bursts; between some bursts valid drops for a random gap. Valid is left high
  // after the handshake so that back-to-back beats keep it high without a glitch.
  task automatic send_beat(input logic op, input logic [31:0] now_ms,
                           input logic [15:0] sensor_mm, input logic [31:0] left_pos,
                           input logic [31:0] right_pos);
    int          gap;
    steer_beat_t b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        steer_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    steer_in.valid          <= 1'b1;
    steer_in.op             <= op;
    steer_in.now_ms         <= now_ms;
    steer_in.sensor_mm      <= sensor_mm;
    steer_in.left_position  <= left_pos;
    steer_in.right_position <= right_pos;
    @(posedge clk);
    while (!steer_in.ready) @(posedge clk);
    b = '{op, now_ms, sensor_mm, left_pos, right_pos};
    last_prediction = predict_drive(b);
    expected_drive.push_back(last_prediction);
  endtask

  // Stops sending and waits until every owed drive has come back and the two-stage
  // pipeline has settled, so that registers can be written safely.
  task automatic drain_results();
    steer_in.valid <= 1'b0;
    burst_left = 0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register. The write valid stays high unless this is the last write of a
  // group, so consecutive writes go out as back-to-back beats.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                           input bit last);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    case (idx)
      REG_TARGET_MM:     cfg_shadow.target_mm     = value[15:0];
      REG_DRIVE_DEGREES: cfg_shadow.drive_degrees = value[30:0];
      REG_WALL_SIDE:     cfg_shadow.wall_side     = value[0];
      REG_BASE_VOLTAGE:  cfg_shadow.base_voltage  = value[13:0];
      REG_TIMEOUT_MS:    cfg_shadow.timeout_ms    = value;
      REG_PROP_GAIN:     cfg_shadow.prop_gain     = value[7:0];
      REG_DERIV_GAIN:    cfg_shadow.deriv_gain    = value[7:0];
      REG_MAX_VALID_MM:  cfg_shadow.max_valid_mm  = value[15:0];
      default: ;
    endcase
    if (last) cfg_wr.valid <= 1'b0;
  endtask

  // Loads a whole setting once the block has gone idle.
  task automatic set_config(input cfg_t c);
    drain_results();
    write_reg(REG_TARGET_MM,     {16'd0, c.target_mm},    1'b0);
    write_reg(REG_DRIVE_DEGREES, {1'b0, c.drive_degrees}, 1'b0);
    write_reg(REG_WALL_SIDE,     {31'd0, c.wall_side},    1'b0);
    write_reg(REG_BASE_VOLTAGE,  {18'd0, c.base_voltage}, 1'b0);
    write_reg(REG_TIMEOUT_MS,    c.timeout_ms,            1'b0);
    write_reg(REG_PROP_GAIN,     {24'd0, c.prop_gain},    1'b0);
    write_reg(REG_DERIV_GAIN,    {24'd0, c.deriv_gain},   1'b0);
    write_reg(REG_MAX_VALID_MM,  {16'd0, c.max_valid_mm}, 1'b1);
  endtask

  // Zero, the top of the range, or anything in between.
  function automatic logic [31:0] pick_value(input logic [31:0] max_val);
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return max_val;
      default: return $urandom_range(0, max_val);
    endcase
  endfunction

  // A setting for one random phase. Values mostly let runs go on for a while, but most
  // registers now and then take an extreme value instead.
  function automatic cfg_t random_config();
    cfg_t c;
    c.target_mm = ($urandom_range(0, 3) == 0) ? 16'(pick_value(32'hFFFF))
                                             : 16'($urandom_range(50, 1500));
    case ($urandom_range(0, 9))
      0:       c.drive_degrees = '0;
      1:       c.drive_degrees = 31'h7FFF_FFFF;
      default: c.drive_degrees = 31'($urandom_range(200, 5000));
    endcase
    c.wall_side = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       c.base_voltage = 14'd0;
      1:       c.base_voltage = VOLT_MAX;
      2:       c.base_voltage = 14'h3FFF;
      default: c.base_voltage = 14'($urandom_range(0, 12000));
    endcase
    case ($urandom_range(0, 9))
      0:       c.timeout_ms = 32'd0;
      1, 2:    c.timeout_ms = 32'hFFFF_FFFF;
      default: c.timeout_ms = $urandom_range(100, 800);
    endcase
    c.prop_gain    = 8'(pick_value(32'hFF));
    c.deriv_gain   = 8'(pick_value(32'hFF));
    c.max_valid_mm = ($urandom_range(0, 4) == 0) ? 16'(pick_value(32'hFFFF))
                                                : 16'($urandom_range(500, 3000));
    return c;
  endfunction

  // Samples before any start come back idle. Right after reset the timeout is zero, so
  // the first sample of a run times out; with a timeout and a base drive written, the
  // reset gains and the reset valid limit shape the drive.
  task automatic test_idle_and_defaults();
    send_beat(OP_SAMPLE, 32'd0, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(OP_START, 32'd77, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd77, 16'd100, 32'd0, 32'd0);
    drain_results();
    write_reg(REG_TIMEOUT_MS, 32'd1000, 1'b0);
    write_reg(REG_DRIVE_DEGREES, 32'd5000, 1'b0);
    write_reg(REG_BASE_VOLTAGE, 32'd6000, 1'b1);
    send_beat(OP_START, 32'd100, 16'd0, 32'd10, 32'd20);
    send_beat(OP_SAMPLE, 32'd110, 16'd100, 32'd15, 32'd25);
    send_beat(OP_SAMPLE, 32'd120, 16'd2000, 32'd20, 32'd30);
  endtask

  // Corrections that saturate at the base drive in both directions, readings at the
  // valid limit, a base drive above the side limit, and zero gains.
  task automatic test_steering_extremes();
    cfg_t c;
    c = '{target_mm: 16'd300, drive_degrees: 31'd1_000_000, wall_side: SIDE_RIGHT,
          base_voltage: 14'd6000, timeout_ms: 32'd100_000, prop_gain: 8'd30,
          deriv_gain: 8'd5, max_valid_mm: 16'd2000};
    set_config(c);
    send_beat(OP_START, 32'd10, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd20, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd30, 16'd300, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd40, 16'd2000, 32'd0, 32'd0);
    c.target_mm    = 16'hFFFF;
    c.wall_side    = SIDE_LEFT;
    c.base_voltage = 14'h3FFF;
    c.prop_gain    = 8'hFF;
    c.deriv_gain   = 8'hFF;
    c.max_valid_mm = 16'hFFFF;
    set_config(c);
    send_beat(OP_START, 32'd10, 16'hFFFF, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd20, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd30, 16'hFFFF, 32'd0, 32'd0);
    // A valid limit of zero rejects every reading, and zero gains leave the base drive.
    c.target_mm    = 16'd0;
    c.base_voltage = VOLT_MAX;
    c.prop_gain    = 8'd0;
    c.deriv_gain   = 8'd0;
    c.max_valid_mm = 16'd0;
    set_config(c);
    send_beat(OP_START, 32'd10, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd20, 16'd0, 32'd0, 32'd0);
  endtask

  // Time that wraps past zero, a timeout hit exactly, travel that wraps the encoder
  // counters and reaches the target exactly, the largest travel target against travel
  // of 2^31 per side, a start while running, and a zero travel target.
  task automatic test_stop_conditions();
    cfg_t c;
    c = '{target_mm: 16'd500, drive_degrees: 31'd1000, wall_side: SIDE_RIGHT,
          base_voltage: 14'd5000, timeout_ms: 32'd500, prop_gain: 8'd30,
          deriv_gain: 8'd5, max_valid_mm: 16'd2000};
    set_config(c);
    send_beat(OP_START, 32'hFFFF_FF00, 16'd400, 32'h7FFF_FFF0, 32'h8000_0010);
    send_beat(OP_SAMPLE, 32'hFFFF_FF00 + 32'd499, 16'd450,
              32'h7FFF_FFF0 + 32'd600, 32'h8000_0010 - 32'd399);
    send_beat(OP_SAMPLE, 32'hFFFF_FF00 + 32'd499, 16'd450,
              32'h7FFF_FFF0 + 32'd1000, 32'h8000_0010 - 32'd1000);
    send_beat(OP_START, 32'd5000, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd5500, 16'd500, 32'd0, 32'd0);
    drain_results();
    write_reg(REG_DRIVE_DEGREES, 32'h7FFF_FFFF, 1'b0);
    write_reg(REG_TIMEOUT_MS, 32'hFFFF_FFFF, 1'b1);
    send_beat(OP_START, 32'd0, 16'd500, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'hFFFF_FFFE, 16'd500, 32'h8000_0000, 32'h7FFF_FFFD);
    send_beat(OP_SAMPLE, 32'hFFFF_FFFE, 16'd500, 32'h8000_0000, 32'h8000_0000);
    // The second start restarts the run and clears the error that the derivative uses.
    send_beat(OP_START, 32'd100, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd200, 16'd100, 32'd0, 32'd0);
    send_beat(OP_START, 32'd300, 16'd0, 32'd0, 32'd0);
    send_beat(OP_SAMPLE, 32'd400, 16'd100, 32'd0, 32'd0);
    drain_results();
    write_reg(REG_DRIVE_DEGREES, 32'd0, 1'b1);
    send_beat(OP_START, 32'd0, 16'd0, 32'd123, 32'd456);
    send_beat(OP_SAMPLE, 32'd1, 16'd0, 32'd123, 32'd456);
  endtask

  // Random phases, each with its own setting and a few runs. A run is a start at a random
  // time and encoder position followed by samples that advance the clock and the wheels a
  // little and read a distance near the target, with some invalid and arbitrary readings.
  // Now and then a fully random beat stands in for a sample, which may also restart the
  // run out of order. Once a run stops, at most a couple of idle samples follow.
  task automatic test_random_runs();
    int          counted;
    int          samples;
    int          near_mm;
    logic [31:0] now_ms;
    logic [31:0] left_pos;
    logic [31:0] right_pos;
    logic [15:0] sensor_mm;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      set_config(random_config());
      repeat ($urandom_range(2, 6)) begin
        now_ms    = $urandom;
        left_pos  = $urandom;
        right_pos = $urandom;
        send_beat(OP_START, now_ms, 16'($urandom_range(0, 65535)), left_pos, right_pos);
        counted++;
        samples = $urandom_range(1, 60);
        while (samples > 0) begin
          samples--;
          if ($urandom_range(0, 11) == 0) begin
            send_beat(1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)),
                      $urandom, $urandom);
          end else begin
            now_ms    = now_ms + $urandom_range(0, 20);
            left_pos  = left_pos + $urandom_range(0, 60) - 32'd10;
            right_pos = right_pos + $urandom_range(0, 60) - 32'd10;
            case ($urandom_range(0, 7))
              0: sensor_mm = 16'($urandom_range(0, 65535));
              1: sensor_mm = 16'(cfg_shadow.max_valid_mm + $urandom_range(0, 3));
              default: begin
                near_mm = int'({16'd0, cfg_shadow.target_mm}) + $urandom_range(0, 400) - 200;
                if (near_mm < 0) near_mm = 0;
                if (near_mm > 65535) near_mm = 65535;
                sensor_mm = near_mm[15:0];
              end
            endcase
            send_beat(OP_SAMPLE, now_ms, sensor_mm, left_pos, right_pos);
          end
          if (last_prediction.status != ST_IDLE) counted++;
          if ((last_prediction.status == ST_TIMEOUT || last_prediction.status == ST_DISTANCE)
              && samples > 2)
            samples = $urandom_range(0, 2);
        end
      end
    end
  endtask

  initial begin
    // The sender's and the register writer's inputs are known from time zero; the
    // receiver's ready follows its stall pattern from the first edge. Reset is held low
    // from time zero, then released.
    rst_n                   <= 1'b0;
    steer_in.valid          <= 1'b0;
    steer_in.op             <= OP_START;
    steer_in.now_ms         <= '0;
    steer_in.sensor_mm      <= '0;
    steer_in.left_position  <= '0;
    steer_in.right_position <= '0;
    cfg_wr.valid            <= 1'b0;
    cfg_wr.index            <= REG_TARGET_MM;
    cfg_wr.data             <= '0;
    cfg_shadow              = '0;
    cfg_shadow.prop_gain    = PROP_GAIN_RST;
    cfg_shadow.deriv_gain   = DERIV_GAIN_RST;
    cfg_shadow.max_valid_mm = MAX_VALID_MM_RST;
    run_start_ms            = '0;
    left_origin             = '0;
    right_origin            = '0;
    last_error              = 0;
    run_active              = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_and_defaults();
    test_steering_extremes();
    test_stop_conditions();
    test_random_runs();

    // Everything has been sent; collect the last drives and let the pipeline settle.
    drain_results();
    if (error_count == 0) begin
      $display("wall_tracking_pd_steering_top: match");
    end else begin
      $display("wall_tracking_pd_steering_top: mismatch");
    end
    $finish;
  end

endmodule

[wall_tracking_pd_steering_top.f]
hdl/wtpd_pkg.sv
hdl/wtpd_if.sv
hdl/wtpd_cfg_regs.sv
hdl/wtpd_stop_check.sv
hdl/wtpd_pd_core.sv
hdl/wall_tracking_pd_steering_top.sv
sim/wall_tracking_pd_steering_top_test.sv
